### rtl/core/cgp_pkg.sv
// shared constants and types for the conic gradient pixel generator
package cgp_pkg;

  localparam int CENTER_W  = 18;
  localparam int ROT_W     = 16;
  localparam int DATA_W    = 64;
  localparam int LANE_W    = 16;
  localparam int LANES     = 4;
  localparam int PRESCALE  = 20;
  localparam int TABLE_LEN = 24;
  localparam int INDEX_W   = 3;

  typedef enum logic [INDEX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_ROTATION    = 3'd2,
    REG_FIRST_COLOR = 3'd3,
    REG_LAST_COLOR  = 3'd4
  } cfg_reg_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [0:TABLE_LEN-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

endpackage

### rtl/core/conic_gradient_pixel.sv
// conic gradient pixel generator: offset, vectoring cordic angle, color blend
// register order: offset, pre-rotation, ANGLE_STAGES cordic, blend, product, output
// throughput: one transaction per cycle unless busy, one cordic iteration per stage
// busy is high only during reset and the cycle that follows; the result
// cannot be stalled and appears for one cycle with strobe
// synchronous reset clears all valid bits and loads the register defaults
module conic_gradient_pixel #(
  parameter int COORD_BITS   = 13,
  parameter int COLOR_BITS   = 16,
  parameter int ANGLE_BITS   = 16,
  parameter int ANGLE_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         pixel_x,
  input  logic [COORD_BITS-1:0]         pixel_y,
  output logic                          strobe,
  output logic [COLOR_BITS-1:0]         red,
  output logic [COLOR_BITS-1:0]         green,
  output logic [COLOR_BITS-1:0]         blue,
  output logic [COLOR_BITS-1:0]         alpha,
  input  logic                          cfg_write,
  input  logic [cgp_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [cgp_pkg::DATA_W-1:0]    cfg_data
);

  localparam int PX_W = COORD_BITS + 4;
  localparam int DW   = ((PX_W > cgp_pkg::CENTER_W) ? PX_W : cgp_pkg::CENTER_W) + 2;
  localparam int CW   = DW + cgp_pkg::PRESCALE + 2;
  localparam int N    = ANGLE_STAGES;
  localparam int LAT  = N + 5;
  localparam int DIFF_W = COLOR_BITS + 1;
  localparam int PW   = COLOR_BITS + ANGLE_BITS + 2;
  localparam logic [31:0] T_ROUND = 32'd1 << (31 - ANGLE_BITS);
  localparam logic signed [PW-1:0] P_ROUND = PW'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [PW-1:0] C_MAX = PW'((1 << COLOR_BITS) - 1);

  // configuration registers
  logic [cgp_pkg::CENTER_W-1:0] center_x;
  logic [cgp_pkg::CENTER_W-1:0] center_y;
  logic [cgp_pkg::ROT_W-1:0]    rotation;
  logic [cgp_pkg::DATA_W-1:0]   first_color;
  logic [cgp_pkg::DATA_W-1:0]   last_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      rotation    <= '0;
      first_color <= '0;
      last_color  <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cgp_pkg::REG_CENTER_X:    center_x    <= cfg_data[cgp_pkg::CENTER_W-1:0];
        cgp_pkg::REG_CENTER_Y:    center_y    <= cfg_data[cgp_pkg::CENTER_W-1:0];
        cgp_pkg::REG_ROTATION:    rotation    <= cfg_data[cgp_pkg::ROT_W-1:0];
        cgp_pkg::REG_FIRST_COLOR: first_color <= cfg_data;
        cgp_pkg::REG_LAST_COLOR:  last_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  logic accept;
  assign accept = start && !busy;

  // offset stage
  logic                 v_d;
  logic signed [DW-1:0] dx_d;
  logic signed [DW-1:0] dy_d;
  logic signed [DW-1:0] px_ext;
  logic signed [DW-1:0] py_ext;
  logic signed [DW-1:0] cx_ext;
  logic signed [DW-1:0] cy_ext;

  assign px_ext = {{(DW-PX_W){1'b0}}, pixel_x, 4'b0};
  assign py_ext = {{(DW-PX_W){1'b0}}, pixel_y, 4'b0};
  assign cx_ext = {{(DW-cgp_pkg::CENTER_W){center_x[cgp_pkg::CENTER_W-1]}}, center_x};
  assign cy_ext = {{(DW-cgp_pkg::CENTER_W){center_y[cgp_pkg::CENTER_W-1]}}, center_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= 1'b0;
    end else begin
      v_d <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dx_d <= px_ext - cx_ext;
    dy_d <= py_ext - cy_ext;
  end

  // cordic pipeline, vector (dy, dx), index 0 is the pre-rotation stage
  logic                 v_c    [0:N];
  logic                 zero_c [0:N];
  logic signed [CW-1:0] x_c    [0:N];
  logic signed [CW-1:0] y_c    [0:N];
  logic [31:0]          acc_c  [0:N];
  logic signed [DW-1:0] xn_p;
  logic signed [DW-1:0] yn_p;

  assign xn_p = dy_d[DW-1] ? -dy_d : dy_d;
  assign yn_p = dy_d[DW-1] ? -dx_d : dx_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c[0] <= 1'b0;
    end else begin
      v_c[0] <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    x_c[0]    <= {{(CW-DW-cgp_pkg::PRESCALE){xn_p[DW-1]}}, xn_p,
                  {cgp_pkg::PRESCALE{1'b0}}};
    y_c[0]    <= {{(CW-DW-cgp_pkg::PRESCALE){yn_p[DW-1]}}, yn_p,
                  {cgp_pkg::PRESCALE{1'b0}}};
    acc_c[0]  <= dy_d[DW-1] ? cgp_pkg::HALF_TURN : 32'd0;
    zero_c[0] <= (dx_d == '0) && (dy_d == '0);
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    assign xs = x_c[i] >>> i;
    assign ys = y_c[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_c[i+1] <= 1'b0;
      end else begin
        v_c[i+1] <= v_c[i];
      end
    end

    always_ff @(posedge clk) begin
      zero_c[i+1] <= zero_c[i];
      if (!y_c[i][CW-1]) begin
        x_c[i+1]   <= x_c[i] + ys;
        y_c[i+1]   <= y_c[i] - xs;
        acc_c[i+1] <= acc_c[i] + cgp_pkg::ATAN_TURNS[i];
      end else begin
        x_c[i+1]   <= x_c[i] - ys;
        y_c[i+1]   <= y_c[i] + xs;
        acc_c[i+1] <= acc_c[i] - cgp_pkg::ATAN_TURNS[i];
      end
    end
  end

  // blend factor and channel differences
  logic                     v_t;
  logic [ANGLE_BITS-1:0]    t_t;
  logic [31:0]              acc_t;
  logic [31:0]              frac_t;
  logic signed [DIFF_W-1:0] diff_t [0:cgp_pkg::LANES-1];
  logic [COLOR_BITS-1:0]    sv_t   [0:cgp_pkg::LANES-1];

  assign acc_t  = zero_c[N] ? 32'd0 : acc_c[N];
  assign frac_t = acc_t + cgp_pkg::HALF_TURN - {rotation, 16'h0000} + T_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t <= 1'b0;
    end else begin
      v_t <= v_c[N];
    end
  end

  always_ff @(posedge clk) begin
    t_t <= frac_t[31 -: ANGLE_BITS];
    for (int k = 0; k < cgp_pkg::LANES; k++) begin
      sv_t[k]   <= first_color[cgp_pkg::LANE_W*k +: COLOR_BITS];
      diff_t[k] <= $signed({1'b0, last_color[cgp_pkg::LANE_W*k +: COLOR_BITS]})
                 - $signed({1'b0, first_color[cgp_pkg::LANE_W*k +: COLOR_BITS]});
    end
  end

  // product stage
  logic                  v_m;
  logic signed [PW-1:0]  prod_m [0:cgp_pkg::LANES-1];
  logic [COLOR_BITS-1:0] sv_m   [0:cgp_pkg::LANES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else begin
      v_m <= v_t;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < cgp_pkg::LANES; k++) begin
      prod_m[k] <= diff_t[k] * $signed({1'b0, t_t});
      sv_m[k]   <= sv_t[k];
    end
  end

  // round, offset and clamp into the output register
  logic signed [PW-1:0]  sum_o  [0:cgp_pkg::LANES-1];
  logic [COLOR_BITS-1:0] chan_o [0:cgp_pkg::LANES-1];
  logic [COLOR_BITS-1:0] out_o  [0:cgp_pkg::LANES-1];

  always_comb begin
    for (int k = 0; k < cgp_pkg::LANES; k++) begin
      sum_o[k] = ((prod_m[k] + P_ROUND) >>> ANGLE_BITS)
               + $signed({{(PW-COLOR_BITS){1'b0}}, sv_m[k]});
      if (sum_o[k][PW-1]) begin
        chan_o[k] = '0;
      end else if (sum_o[k] > C_MAX) begin
        chan_o[k] = '1;
      end else begin
        chan_o[k] = sum_o[k][COLOR_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < cgp_pkg::LANES; k++) begin
      out_o[k] <= chan_o[k];
    end
  end

  assign red   = out_o[0];
  assign green = out_o[1];
  assign blue  = out_o[2];
  assign alpha = out_o[3];

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT strobe)
    else $error("accepted transaction did not produce a result on time");

  a_source : assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept, LAT))
    else $error("result without a matching transaction");

  a_flush : assert property (@(posedge clk)
    rst |=> !strobe && !v_d && !v_t && !v_m)
    else $error("valid bits not cleared by reset");
`endif

endmodule
